/* rtl/hcfr_pkg.sv */
// Shared types, codes and the CRC-16 CCITT byte update for the HDLC frame receiver.
package hcfr_pkg;

   localparam int HCFR_MAX_MESSAGE_BYTES = 256;
   localparam logic [3:0] HCFR_MIN_PREAMBLE_RESET = 4'd10;
   localparam logic [15:0] HCFR_CRC_INIT = 16'hffff;
   localparam logic [15:0] HCFR_CRC_POLY = 16'h1021;
   localparam logic [15:0] HCFR_CRC_RESIDUE = 16'h1d0f;
   localparam logic [7:0] HCFR_ADDRESS = 8'hff;
   localparam logic [7:0] HCFR_CONTROL_A = 8'hc0;
   localparam logic [7:0] HCFR_CONTROL_B = 8'hc8;

   typedef enum logic [2:0] {
      FUNC_DATA    = 3'd0,
      FUNC_FLAG    = 3'd1,
      FUNC_ABORT   = 3'd2,
      FUNC_TIMEOUT = 3'd3,
      FUNC_START   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_STATUS  = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_GOOD        = 3'd0,
      STATUS_TOO_LONG    = 3'd1,
      STATUS_TOO_SHORT   = 3'd2,
      STATUS_CRC_ERROR   = 3'd3,
      STATUS_BAD_ADDRESS = 3'd4,
      STATUS_BAD_CONTROL = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      MODE_HUNT    = 3'b001,
      MODE_FLAGS   = 3'b010,
      MODE_COLLECT = 3'b100
   } mode_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      status_type status;
      logic       final_frame;
      logic [7:0] payload_length;
   } result_type;

   // Bit-serial CRC, MSB first, unrolled over one octet.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] octet);
      logic [15:0] r;
      logic        top;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         top = r[15] ^ octet[i];
         r = {r[14:0], 1'b0};
         if (top) begin
            r = r ^ HCFR_CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

/* rtl/hdlc_control_frame_receiver.sv */
// Top level of the HDLC control-frame receiver: input register, engine and result register.
//
// Takes one deframed HDLC symbol per word and returns at most one result word per symbol.
// A symbol sits in the input register while the receiver logic, including a
// byte-wide CRC-16 update, computes the next state and the result in a single pass; the
// result lands in an output register. Throughput is one symbol per clock cycle while the
// output is not stalled; the only stall comes from the output register when the consumer
// holds rsp_tready low. There is no clearing pass after reset.
module hdlc_control_frame_receiver
   import hcfr_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = HCFR_MAX_MESSAGE_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,  // min_preamble_flags
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic [2:0]  req_tuser,    // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] payload_byte, [10:8] frame_status,
                                     // [11] final_frame, [19:12] payload_length, zero pad
   output logic [1:0]  rsp_tuser     // [1:0] result_kind
);

   logic [3:0] min_flags_ff;
   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_func_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       res_valid;
   result_type res;
   result_type held;

   assign advance     = in_valid_ff & (~rsp_tvalid | rsp_tready);
   assign req_tready  = ~in_valid_ff | advance;
   assign in_valid_in = (req_tvalid & req_tready) | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_flags_ff <= HCFR_MIN_PREAMBLE_RESET;
         in_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_flags_ff <= csr_wr_data;
         end
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   hcfr_rx_engine #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .min_preamble_flags (min_flags_ff),
      .fire               (advance),
      .func               (in_func_ff),
      .data_byte          (in_byte_ff),
      .res_valid          (res_valid),
      .res                (res)
   );

   hcfr_result_reg u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .held       (held)
   );

   assign rsp_tuser = held.kind;
   assign rsp_tdata = {4'd0, held.payload_length, held.final_frame, held.status,
                       held.payload_byte};

endmodule

/* rtl/hcfr_rx_engine.sv */
// Receiver state registers and the single-pass next-state and result logic.
module hcfr_rx_engine
   import hcfr_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = HCFR_MAX_MESSAGE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] min_preamble_flags,
   input  logic       fire,
   input  logic [2:0] func,
   input  logic [7:0] data_byte,
   output logic       res_valid,
   output result_type res
);

   localparam int BCW = $clog2(MAX_MESSAGE_BYTES + 1);

   mode_type     mode_ff, mode_in;
   logic [3:0]   flag_count_ff, flag_count_in;
   logic         expect_ff, expect_in;
   logic [BCW-1:0] byte_count_ff, byte_count_in;
   logic [15:0]  crc_ff, crc_in;
   logic [7:0]   delay0_ff, delay0_in;
   logic [7:0]   delay1_ff, delay1_in;
   logic [7:0]   address_ff, address_in;
   logic [7:0]   control_ff, control_in;

   logic           fresh;
   logic           do_store;
   logic [BCW-1:0] bc_base;
   logic [15:0]    crc_base;
   logic [7:0]     d0_base;
   logic [7:0]     d1_base;

   always_comb begin
      mode_in       = mode_ff;
      flag_count_in = flag_count_ff;
      expect_in     = expect_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      delay0_in     = delay0_ff;
      delay1_in     = delay1_ff;
      address_in    = address_ff;
      control_in    = control_ff;
      res_valid     = 1'b0;
      res           = '0;
      fresh         = 1'b0;
      do_store      = 1'b0;

      if (fire) begin
         unique case (func)
            FUNC_START: begin
               mode_in       = MODE_HUNT;
               flag_count_in = 4'd0;
               expect_in     = 1'b1;
            end
            FUNC_TIMEOUT: begin
               mode_in       = MODE_HUNT;
               flag_count_in = 4'd0;
               expect_in     = 1'b1;
               res_valid     = 1'b1;
               res.kind      = KIND_TIMEOUT;
            end
            FUNC_DATA, FUNC_FLAG, FUNC_ABORT: begin
               if (mode_ff == MODE_COLLECT) begin
                  if (func == FUNC_FLAG) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_STATUS;
                     priority if (byte_count_ff < BCW'(5)) begin
                        res.status = STATUS_TOO_SHORT;
                     end else if (crc_ff != HCFR_CRC_RESIDUE) begin
                        res.status = STATUS_CRC_ERROR;
                     end else if (address_ff != HCFR_ADDRESS) begin
                        res.status = STATUS_BAD_ADDRESS;
                     end else if (control_ff != HCFR_CONTROL_A &&
                                  control_ff != HCFR_CONTROL_B) begin
                        res.status = STATUS_BAD_CONTROL;
                     end else begin
                        res.status         = STATUS_GOOD;
                        res.final_frame    = control_ff[3];
                        res.payload_length = 8'(byte_count_ff - BCW'(4));
                        expect_in          = control_ff[3];
                     end
                     mode_in       = MODE_FLAGS;
                     flag_count_in = 4'd1;
                  end else if (byte_count_ff >= BCW'(MAX_MESSAGE_BYTES)) begin
                     mode_in       = MODE_HUNT;
                     flag_count_in = 4'd0;
                     res_valid     = 1'b1;
                     res.kind      = KIND_STATUS;
                     res.status    = STATUS_TOO_LONG;
                  end else if (func == FUNC_DATA) begin
                     do_store = 1'b1;
                  end
               end else if (func == FUNC_FLAG) begin
                  if (mode_ff == MODE_FLAGS) begin
                     if (flag_count_ff != 4'd15) begin
                        flag_count_in = flag_count_ff + 4'd1;
                     end
                  end else begin
                     mode_in       = MODE_FLAGS;
                     flag_count_in = 4'd1;
                  end
               end else if (mode_ff == MODE_FLAGS) begin
                  if (expect_ff && flag_count_ff < min_preamble_flags) begin
                     // Preamble too short for the first frame: skip this frame.
                     mode_in       = MODE_HUNT;
                     flag_count_in = 4'd0;
                  end else begin
                     mode_in       = MODE_COLLECT;
                     flag_count_in = 4'd0;
                     fresh         = 1'b1;
                     do_store      = (func == FUNC_DATA);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      bc_base  = fresh ? '0 : byte_count_ff;
      crc_base = fresh ? HCFR_CRC_INIT : crc_ff;
      d0_base  = fresh ? 8'd0 : delay0_ff;
      d1_base  = fresh ? 8'd0 : delay1_ff;

      if (fresh) begin
         byte_count_in = '0;
         crc_in        = HCFR_CRC_INIT;
         delay0_in     = 8'd0;
         delay1_in     = 8'd0;
         address_in    = 8'd0;
         control_in    = 8'd0;
      end

      if (do_store) begin
         if (bc_base == BCW'(0)) begin
            address_in = data_byte;
         end
         if (bc_base == BCW'(1)) begin
            control_in = data_byte;
         end
         // The word two octets back is certain payload once four octets are in.
         if (bc_base >= BCW'(4)) begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = d1_base;
         end
         delay1_in     = d0_base;
         delay0_in     = data_byte;
         crc_in        = crc16_byte(crc_base, data_byte);
         byte_count_in = bc_base + BCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_HUNT;
         flag_count_ff <= 4'd0;
         expect_ff     <= 1'b1;
         byte_count_ff <= '0;
         crc_ff        <= HCFR_CRC_INIT;
         delay0_ff     <= 8'd0;
         delay1_ff     <= 8'd0;
         address_ff    <= 8'd0;
         control_ff    <= 8'd0;
      end else begin
         mode_ff       <= mode_in;
         flag_count_ff <= flag_count_in;
         expect_ff     <= expect_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         delay0_ff     <= delay0_in;
         delay1_ff     <= delay1_in;
         address_ff    <= address_in;
         control_ff    <= control_in;
      end
   end

endmodule

/* rtl/hcfr_result_reg.sv */
// Output register holding one result word until the consumer takes it.
module hcfr_result_reg
   import hcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output result_type held
);

   logic       valid_ff, valid_in;
   result_type held_ff;

   assign valid_in   = load | (valid_ff & ~rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign held       = held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= res;
      end
   end

endmodule
